// ----- rtl/core/hlcp_pkg.sv -----
// Shared types, constants and register codes for the hop-limited cheapest path core.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package hlcp_pkg;

   // Field widths of the channel words and registers
   localparam int NODE_W     = 6;
   localparam int COUNT_W    = 7;
   localparam int PRICE_IN_W = 16;
   localparam int OUT_COST_W = 22;
   localparam int COST_W     = 23;
   localparam int STOPS_W    = 6;

   // Path cost encodings: all ones marks an unreached node
   localparam logic [COST_W-1:0] COST_INF = 23'h7FFFFF;
   localparam logic [COST_W-1:0] COST_SAT = 23'h3FFFFF;

   // Defaults for the top level parameters
   localparam int DEF_MAX_NODES  = 64;
   localparam int DEF_MAX_EDGES  = 256;
   localparam int DEF_PRICE_BITS = 16;

   // Configuration register indexes
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_STOPS  = 2'd3;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_INIT,
      ST_COPY,
      ST_EDGE_RD,
      ST_EDGE_OP,
      ST_EDGE_ADD,
      ST_EDGE_WR,
      ST_ROUND_END,
      ST_DEST_RD,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic              en;
      logic [COST_W-1:0] base;
   } relax_req_type;

   typedef struct packed {
      logic              vld;
      logic [COST_W-1:0] cost;
   } relax_rsp_type;

endpackage

// ----- rtl/core/hlcp_if.sv -----
// Valid/ready channel interfaces for the edge words and the result words.
// Standalone; widths match the field widths of hlcp_pkg.
`timescale 1ns / 1ps

interface hlcp_req_if;
   logic        valid;
   logic        ready;
   logic [5:0]  from_node;
   logic [5:0]  to_node;
   logic [15:0] edge_price;
   logic        last_edge;

   modport source (output valid, from_node, to_node, edge_price, last_edge, input ready);
   modport sink (input valid, from_node, to_node, edge_price, last_edge, output ready);
endinterface

interface hlcp_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [21:0] cheapest_cost;
   logic        edges_dropped;

   modport source (output valid, found, cheapest_cost, edges_dropped, input ready);
   modport sink (input valid, found, cheapest_cost, edges_dropped, output ready);
endinterface

// ----- rtl/core/hlcp_relax.sv -----
// Shared relaxation adder: base cost plus edge price, saturated and registered.
// Depends on hlcp_pkg.
`timescale 1ns / 1ps

module hlcp_relax #(
   parameter int PRICE_BITS = hlcp_pkg::DEF_PRICE_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  hlcp_pkg::relax_req_type req,
   input  logic [PRICE_BITS-1:0]   price,
   output hlcp_pkg::relax_rsp_type rsp
);
   import hlcp_pkg::*;

   localparam int SUM_W = ((PRICE_BITS > COST_W) ? PRICE_BITS : COST_W) + 1;

   logic [SUM_W-1:0]  sum;
   logic [COST_W-1:0] cost_in;
   logic [COST_W-1:0] cost_ff;
   logic              vld_ff;

   always_comb begin
      sum = SUM_W'(req.base) + SUM_W'(price);
      if (sum > SUM_W'(COST_SAT)) begin
         cost_in = COST_SAT;
      end else begin
         cost_in = sum[COST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= req.en;
      end
      cost_ff <= cost_in;
   end

   assign rsp.vld  = vld_ff;
   assign rsp.cost = cost_ff;

endmodule

// ----- rtl/core/hop_limited_cheapest_path_core.sv -----
// Hop-limited cheapest path: edges stream in one word per cycle and in-range ones are stored;
// the word with last_edge set starts a bounded Bellman-Ford search of max_stops+1 rounds and
// yields one result word (found, cost, drop flag). During the search req.ready is low. Each
// round copies the node costs through one read port, then relaxes the stored edges one at a
// time through a single saturating adder, each in four steps: read, operand, add, write.
// An edge that names an out-of-range node takes only the read and operand steps.
`timescale 1ns / 1ps

module hop_limited_cheapest_path_core #(
   parameter int MAX_NODES  = hlcp_pkg::DEF_MAX_NODES,
   parameter int MAX_EDGES  = hlcp_pkg::DEF_MAX_EDGES,
   parameter int PRICE_BITS = hlcp_pkg::DEF_PRICE_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   hlcp_req_if.sink                         req,
   hlcp_rsp_if.source                       rsp,
   input  logic                             csr_wr_en,
   input  logic [hlcp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hlcp_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import hlcp_pkg::*;

   localparam int NAW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int NCW    = $clog2(MAX_NODES + 1);
   localparam int EAW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int EW     = $clog2(MAX_EDGES + 1);
   localparam int IW     = (NCW > EW) ? NCW : EW;
   localparam int EDGE_W = 2 * NODE_W + PRICE_BITS;

   // configuration
   logic [COUNT_W-1:0] node_count_ff;
   logic [NODE_W-1:0]  source_ff;
   logic [NODE_W-1:0]  dest_ff;
   logic [STOPS_W-1:0] max_stops_ff;
   logic [NCW-1:0]     n_eff;

   // sequencer
   state_type          state_ff, state_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic [STOPS_W-1:0] round_ff, round_in;
   logic               sel_ff, sel_in;
   logic [EW-1:0]      edge_total_ff, edge_total_in;
   logic               overflow_ff, overflow_in;
   logic               invalid_ff, invalid_in;
   logic               cp_wr_ff, cp_wr_in;
   logic [NAW-1:0]     cp_addr_ff, cp_addr_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic [OUT_COST_W-1:0] rsp_cost_ff, rsp_cost_in;
   logic                  rsp_drop_ff, rsp_drop_in;

   // edge store
   logic [EDGE_W-1:0] edge_mem [MAX_EDGES];
   logic [EDGE_W-1:0] edge_rd_ff;
   logic              edge_we;
   logic [EDGE_W-1:0] edge_wdata;
   logic [NODE_W-1:0] e_from;
   logic [NODE_W-1:0] e_to;
   logic [PRICE_BITS-1:0] e_price;
   logic              e_ok;

   // cost banks: one holds the previous round, the other the round being built
   logic [COST_W-1:0] bank0 [MAX_NODES];
   logic [COST_W-1:0] bank1 [MAX_NODES];
   logic [COST_W-1:0] rd0_ff, rd1_ff;
   logic [NAW-1:0]    cur_raddr, nxt_raddr, raddr0, raddr1;
   logic [COST_W-1:0] cur_rd, nxt_rd;
   logic              bk_we, bk_wr_nxt;
   logic [NAW-1:0]    bk_waddr;
   logic [COST_W-1:0] bk_wdata;
   logic              we0, we1;

   relax_req_type     relax_req;
   relax_rsp_type     relax_rsp;

   logic              accept;
   logic              in_ok;
   logic              found_now;

   function automatic logic node_ok(input logic [NODE_W-1:0] x, input logic [NCW-1:0] n);
      return 32'(x) < 32'(n);
   endfunction

   assign n_eff = (32'(node_count_ff) > MAX_NODES) ? NCW'(MAX_NODES) : NCW'(node_count_ff);

   assign e_from  = edge_rd_ff[EDGE_W-1 -: NODE_W];
   assign e_to    = edge_rd_ff[PRICE_BITS+NODE_W-1 -: NODE_W];
   assign e_price = edge_rd_ff[PRICE_BITS-1:0];
   assign e_ok    = node_ok(e_from, n_eff) && node_ok(e_to, n_eff);

   assign req.ready = (state_ff == ST_LOAD);
   assign accept    = req.valid && req.ready;
   assign in_ok     = node_ok(req.from_node, n_eff) && node_ok(req.to_node, n_eff);
   assign edge_wdata = {req.from_node, req.to_node, PRICE_BITS'(req.edge_price)};

   assign cur_rd = sel_ff ? rd1_ff : rd0_ff;
   assign nxt_rd = sel_ff ? rd0_ff : rd1_ff;
   assign raddr0 = sel_ff ? nxt_raddr : cur_raddr;
   assign raddr1 = sel_ff ? cur_raddr : nxt_raddr;
   assign we0    = bk_we && (bk_wr_nxt == sel_ff);
   assign we1    = bk_we && (bk_wr_nxt != sel_ff);

   assign found_now = !invalid_ff && (cur_rd != COST_INF);

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.found         = rsp_found_ff;
   assign rsp.cheapest_cost = rsp_cost_ff;
   assign rsp.edges_dropped = rsp_drop_ff;

   hlcp_relax #(
      .PRICE_BITS (PRICE_BITS)
   ) u_relax (
      .clock (clock),
      .reset (reset),
      .req   (relax_req),
      .price (e_price),
      .rsp   (relax_rsp)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= COUNT_W'(64);
         source_ff     <= '0;
         dest_ff       <= '0;
         max_stops_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_NODE_COUNT: node_count_ff <= csr_wr_data;
            CSR_SOURCE:     source_ff     <= csr_wr_data[NODE_W-1:0];
            CSR_DEST:       dest_ff       <= csr_wr_data[NODE_W-1:0];
            CSR_MAX_STOPS:  max_stops_ff  <= csr_wr_data[STOPS_W-1:0];
            default:        ;
         endcase
      end
   end

   // edge store
   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[edge_total_ff[EAW-1:0]] <= edge_wdata;
      end
      edge_rd_ff <= edge_mem[idx_ff[EAW-1:0]];
   end

   // cost banks
   always_ff @(posedge clock) begin
      if (we0) begin
         bank0[bk_waddr] <= bk_wdata;
      end
      rd0_ff <= bank0[raddr0];
   end

   always_ff @(posedge clock) begin
      if (we1) begin
         bank1[bk_waddr] <= bk_wdata;
      end
      rd1_ff <= bank1[raddr1];
   end

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         idx_ff        <= '0;
         round_ff      <= '0;
         sel_ff        <= 1'b0;
         edge_total_ff <= '0;
         overflow_ff   <= 1'b0;
         invalid_ff    <= 1'b0;
         cp_wr_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         round_ff      <= round_in;
         sel_ff        <= sel_in;
         edge_total_ff <= edge_total_in;
         overflow_ff   <= overflow_in;
         invalid_ff    <= invalid_in;
         cp_wr_ff      <= cp_wr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cp_addr_ff   <= cp_addr_in;
      rsp_found_ff <= rsp_found_in;
      rsp_cost_ff  <= rsp_cost_in;
      rsp_drop_ff  <= rsp_drop_in;
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      round_in      = round_ff;
      sel_in        = sel_ff;
      edge_total_in = edge_total_ff;
      overflow_in   = overflow_ff;
      invalid_in    = invalid_ff;
      cp_wr_in      = 1'b0;
      cp_addr_in    = idx_ff[NAW-1:0];
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_found_in  = rsp_found_ff;
      rsp_cost_in   = rsp_cost_ff;
      rsp_drop_in   = rsp_drop_ff;

      edge_we        = 1'b0;
      cur_raddr      = idx_ff[NAW-1:0];
      nxt_raddr      = NAW'(e_to);
      bk_we          = 1'b0;
      bk_wr_nxt      = 1'b1;
      bk_waddr       = cp_addr_ff;
      bk_wdata       = cur_rd;
      relax_req.en   = 1'b0;
      relax_req.base = cur_rd;

      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (in_ok) begin
                  if (32'(edge_total_ff) < MAX_EDGES) begin
                     edge_we       = 1'b1;
                     edge_total_in = edge_total_ff + 1'b1;
                  end else begin
                     overflow_in = 1'b1;
                  end
               end
               if (req.last_edge) begin
                  idx_in = '0;
                  if (node_ok(source_ff, n_eff) && node_ok(dest_ff, n_eff)) begin
                     invalid_in = 1'b0;
                     state_in   = ST_INIT;
                  end else begin
                     invalid_in = 1'b1;
                     state_in   = ST_FINISH;
                  end
               end
            end
         end

         ST_INIT: begin
            // seed the current bank: zero at the source, unreached elsewhere
            bk_we     = 1'b1;
            bk_wr_nxt = 1'b0;
            bk_waddr  = idx_ff[NAW-1:0];
            bk_wdata  = (idx_ff == IW'(source_ff)) ? '0 : COST_INF;
            if ((idx_ff + 1'b1) == IW'(n_eff)) begin
               idx_in   = '0;
               round_in = '0;
               state_in = ST_COPY;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         ST_COPY: begin
            // read one node per cycle and write it to the next bank in the cycle after the read
            bk_we = cp_wr_ff;
            if (idx_ff < IW'(n_eff)) begin
               cp_wr_in = 1'b1;
               idx_in   = idx_ff + 1'b1;
            end else if (!cp_wr_ff) begin
               idx_in = '0;
               if (edge_total_ff == '0) begin
                  state_in = ST_ROUND_END;
               end else begin
                  state_in = ST_EDGE_RD;
               end
            end
         end

         ST_EDGE_RD: begin
            state_in = ST_EDGE_OP;
         end

         ST_EDGE_OP: begin
            cur_raddr = NAW'(e_from);
            if (e_ok) begin
               state_in = ST_EDGE_ADD;
            end else if ((idx_ff + 1'b1) == IW'(edge_total_ff)) begin
               state_in = ST_ROUND_END;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_EDGE_RD;
            end
         end

         ST_EDGE_ADD: begin
            cur_raddr    = NAW'(e_from);
            relax_req.en = (cur_rd != COST_INF);
            state_in     = ST_EDGE_WR;
         end

         ST_EDGE_WR: begin
            cur_raddr = NAW'(e_from);
            bk_waddr  = NAW'(e_to);
            bk_wdata  = relax_rsp.cost;
            bk_we     = relax_rsp.vld && (relax_rsp.cost < nxt_rd);
            if ((idx_ff + 1'b1) == IW'(edge_total_ff)) begin
               state_in = ST_ROUND_END;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_EDGE_RD;
            end
         end

         ST_ROUND_END: begin
            // the bank just built becomes the current one
            sel_in = !sel_ff;
            idx_in = '0;
            if (round_ff == max_stops_ff) begin
               state_in = ST_DEST_RD;
            end else begin
               round_in = round_ff + 1'b1;
               state_in = ST_COPY;
            end
         end

         ST_DEST_RD: begin
            cur_raddr = NAW'(dest_ff);
            state_in  = ST_FINISH;
         end

         ST_FINISH: begin
            cur_raddr = NAW'(dest_ff);
            // hold until the result register is free
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = found_now;
               rsp_cost_in   = found_now ? cur_rd[OUT_COST_W-1:0] : '0;
               rsp_drop_in   = overflow_ff;
               edge_total_in = '0;
               overflow_in   = 1'b0;
               idx_in        = '0;
               state_in      = ST_LOAD;
            end
         end

         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule

// ----- test/hop_limited_cheapest_path_core_test.sv -----
// Self-checking testbench for hop_limited_cheapest_path_core: streams edge batches,
// predicts each batch's cheapest hop-limited route and checks every result word.
// Depends on hlcp_pkg, hlcp_req_if / hlcp_rsp_if and the core itself.
`timescale 1ns / 1ps

module hop_limited_cheapest_path_core_test;
   import hlcp_pkg::*;

   localparam int MAX_NODES     = DEF_MAX_NODES;
   localparam int MAX_EDGES     = DEF_MAX_EDGES;
   localparam int EDGE_GOAL     = 1800;
   localparam int LONG_HOLD     = 3000;
   localparam int SETTLE_CYCLES = 16;

   typedef struct packed {
      logic [NODE_W-1:0]     from_node;
      logic [NODE_W-1:0]     to_node;
      logic [PRICE_IN_W-1:0] edge_price;
      logic                  last_edge;
   } edge_word_type;

   typedef struct packed {
      logic                  found;
      logic [OUT_COST_W-1:0] cheapest_cost;
      logic                  edges_dropped;
   } route_word_type;

   class route_scoreboard;
      logic [COUNT_W-1:0] node_count;
      logic [NODE_W-1:0]  source_node;
      logic [NODE_W-1:0]  dest_node;
      logic [STOPS_W-1:0] max_stops;
      edge_word_type      kept_edges[$];
      bit                 store_overflow;
      route_word_type     pending_routes[$];
      int                 mismatches;
      int                 routes_checked;
      int                 batches;
      int                 counted_edges;
      int                 dropped_batches;
      int                 found_routes;

      function new();
         node_count     = 7'd64;
         source_node    = '0;
         dest_node      = '0;
         max_stops      = '0;
         store_overflow = 1'b0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_NODE_COUNT: node_count  = value;
            CSR_SOURCE:     source_node = value[NODE_W-1:0];
            CSR_DEST:       dest_node   = value[NODE_W-1:0];
            CSR_MAX_STOPS:  max_stops   = value[STOPS_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned live_nodes();
         return (node_count > MAX_NODES) ? MAX_NODES : node_count;
      endfunction

      // Hop-bounded relaxation: every round reads only the previous round's costs
      function route_word_type cheapest_route();
         logic [COST_W-1:0] best [MAX_NODES];
         logic [COST_W-1:0] relaxed [MAX_NODES];
         logic [COST_W:0]   path_sum;
         int unsigned       n;
         route_word_type    r;
         r = '0;
         r.edges_dropped = store_overflow;
         n = live_nodes();
         if (source_node >= n || dest_node >= n)
            return r;
         for (int i = 0; i < MAX_NODES; i++)
            best[i] = COST_INF;
         best[source_node] = '0;
         for (int hop = 0; hop <= max_stops; hop++) begin
            relaxed = best;
            foreach (kept_edges[k]) begin
               if (best[kept_edges[k].from_node] != COST_INF) begin
                  path_sum = (COST_W+1)'(best[kept_edges[k].from_node]) +
                             (COST_W+1)'(kept_edges[k].edge_price);
                  if (path_sum > (COST_W+1)'(COST_SAT))
                     path_sum = (COST_W+1)'(COST_SAT);
                  if (path_sum[COST_W-1:0] < relaxed[kept_edges[k].to_node])
                     relaxed[kept_edges[k].to_node] = path_sum[COST_W-1:0];
               end
            end
            best = relaxed;
         end
         if (best[dest_node] == COST_INF)
            return r;
         r.found = 1'b1;
         r.cheapest_cost = best[dest_node][OUT_COST_W-1:0];
         return r;
      endfunction

      function void note_edge(edge_word_type w);
         int unsigned n;
         n = live_nodes();
         if (w.from_node < n && w.to_node < n) begin
            counted_edges++;
            if (kept_edges.size() < MAX_EDGES)
               kept_edges.insert(kept_edges.size(), w);
            else
               store_overflow = 1'b1;
         end
         if (w.last_edge) begin
            pending_routes.insert(pending_routes.size(), cheapest_route());
            if (pending_routes[$].found)
               found_routes++;
            if (store_overflow)
               dropped_batches++;
            batches++;
            kept_edges.delete();
            store_overflow = 1'b0;
         end
      endfunction

      function void check_route(route_word_type got);
         route_word_type want;
         if (pending_routes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result word with none pending: found=%0b cost=%0d dropped=%0b",
                        $realtime, got.found, got.cheapest_cost, got.edges_dropped);
            return;
         end
         want = pending_routes.pop_front();
         routes_checked++;
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result mismatch: expected found=%0b cost=%0d dropped=%0b, %s",
                        $realtime, want.found, want.cheapest_cost, want.edges_dropped,
                        $sformatf("got found=%0b cost=%0d dropped=%0b",
                                  got.found, got.cheapest_cost, got.edges_dropped));
         end
      endfunction

      function int unsigned pending();
         return pending_routes.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   hlcp_req_if req_if();
   hlcp_rsp_if rsp_if();

   route_scoreboard board = new();
   bit hold_request = 1'b0;
   int burst_left   = 0;
   int reg_settings = 0;
   int long_holds   = 0;

   hop_limited_cheapest_path_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
         board.check_route({rsp_if.found, rsp_if.cheapest_cost, rsp_if.edges_dropped});
   end

   // Result side: short random ready pattern, or one long hold when asked
   initial begin
      int stretch;
      rsp_if.ready = 1'b0;
      forever begin
         if (hold_request) begin
            @(negedge clock);
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
            hold_request = 1'b0;
            long_holds++;
         end else begin
            stretch = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 12);
            @(negedge clock);
            rsp_if.ready <= 1'b1;
            repeat (stretch - 1) @(negedge clock);
            stretch = $urandom_range(0, 5);
            if (stretch > 0) begin
               @(negedge clock);
               rsp_if.ready <= 1'b0;
               repeat (stretch - 1) @(negedge clock);
            end
         end
      end
   end

   initial begin
      #(60_000_000);
      $display("Verification failed");
      $finish;
   end

   task automatic offer_edge(edge_word_type w);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      @(negedge clock);
      req_if.valid      <= 1'b1;
      req_if.from_node  <= w.from_node;
      req_if.to_node    <= w.to_node;
      req_if.edge_price <= w.edge_price;
      req_if.last_edge  <= w.last_edge;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      board.note_edge(w);
   endtask

   task automatic send_edge(int unsigned from_node, int unsigned to_node,
                            int unsigned edge_price, bit last_edge);
      offer_edge({from_node[NODE_W-1:0], to_node[NODE_W-1:0],
                  edge_price[PRICE_IN_W-1:0], last_edge});
   endtask

   function automatic edge_word_type random_edge(bit last_edge, int unsigned noise_pct);
      edge_word_type w;
      int unsigned   span;
      span = board.live_nodes();
      case ($urandom_range(0, 7))
         0:       w.edge_price = '0;
         1:       w.edge_price = '1;
         2, 3:    w.edge_price = PRICE_IN_W'($urandom_range(1, 20));
         default: w.edge_price = PRICE_IN_W'($urandom);
      endcase
      if (span == 0) begin
         w.from_node = NODE_W'($urandom_range(0, 63));
         w.to_node   = NODE_W'($urandom_range(0, 63));
      end else if (span < MAX_NODES && $urandom_range(0, 99) < noise_pct) begin
         // out-of-range endpoint on one side or the other
         w.from_node = NODE_W'($urandom_range(0, 63));
         w.to_node   = NODE_W'($urandom_range(span, 63));
         if ($urandom_range(0, 1))
            {w.from_node, w.to_node} = {w.to_node, w.from_node};
      end else begin
         w.from_node = NODE_W'($urandom_range(0, span - 1));
         w.to_node   = NODE_W'($urandom_range(0, span - 1));
      end
      w.last_edge = last_edge;
      return w;
   endfunction

   task automatic send_batch(int unsigned size, int unsigned noise_pct);
      for (int unsigned i = 0; i < size; i++)
         offer_edge(random_edge(i == size - 1, noise_pct));
   endtask

   // Drop valid and hold until every predicted result has been taken
   task automatic wait_until_idle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] index, int unsigned value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= value[CSR_DATA_W-1:0];
      board.write_reg(index, value[CSR_DATA_W-1:0]);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic configure(int unsigned nodes, int unsigned source, int unsigned dest,
                            int unsigned stops);
      wait_until_idle();
      write_reg(CSR_NODE_COUNT, nodes);
      write_reg(CSR_SOURCE, source);
      write_reg(CSR_DEST, dest);
      write_reg(CSR_MAX_STOPS, stops);
      reg_settings++;
   endtask

   initial begin
      int unsigned nodes;
      int unsigned live;
      int unsigned source;
      int unsigned dest;
      int unsigned stops;
      int unsigned size;
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_index          = CSR_NODE_COUNT;
      csr_wr_data        = '0;
      req_if.valid       = 1'b0;
      req_if.from_node   = '0;
      req_if.to_node     = '0;
      req_if.edge_price  = '0;
      req_if.last_edge   = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: source and destination coincide, zero-edge route
      send_edge(0, 5, 0, 1);
      configure(64, 0, 63, 63);
      send_edge(63, 0, 65535, 0);
      send_edge(0, 63, 65535, 1);
      // Cheaper three-hop route must lose to the two-hop limit
      configure(4, 0, 3, 1);
      send_edge(0, 1, 10, 0);
      send_edge(1, 2, 10, 0);
      send_edge(2, 3, 10, 0);
      send_edge(5, 1, 3, 0);
      send_edge(0, 3, 100, 0);
      send_edge(1, 63, 7, 0);
      send_edge(1, 3, 50, 1);
      configure(4, 5, 2, 3);
      send_edge(0, 1, 1, 1);
      configure(0, 0, 0, 2);
      send_edge(0, 0, 0, 1);
      configure(100, 0, 2, 0);
      send_edge(0, 1, 1, 0);
      send_edge(1, 2, 1, 1);
      configure(127, 2, 0, 1);
      send_edge(2, 1, 65535, 0);
      send_edge(1, 0, 65535, 1);
      configure(1, 0, 0, 0);
      send_edge(0, 0, 5, 1);

      // Stall the result side long enough to back up the edge input
      configure(8, 0, 7, 2);
      hold_request = 1'b1;
      burst_left   = 200;
      repeat (4) send_batch($urandom_range(6, 12), 0);
      wait_until_idle();

      // Store capacity: overflow, exactly full, then a clean batch
      configure(8, 1, 6, 1);
      send_batch(300, 0);
      send_batch(MAX_EDGES, 0);
      send_batch(5, 0);

      configure(64, 63, 0, 63);
      repeat (3) send_batch($urandom_range(1, 10), 0);

      while (board.counted_edges < EDGE_GOAL) begin
         case ($urandom_range(0, 19))
            0:       nodes = 0;
            1:       nodes = 1;
            2:       nodes = 64;
            3:       nodes = $urandom_range(65, 127);
            4, 5:    nodes = $urandom_range(17, 63);
            default: nodes = $urandom_range(2, 16);
         endcase
         live = (nodes > MAX_NODES) ? MAX_NODES : nodes;
         if (live > 0 && $urandom_range(0, 9) != 0) begin
            source = $urandom_range(0, live - 1);
            dest   = $urandom_range(0, live - 1);
         end else begin
            source = $urandom_range(0, 63);
            dest   = $urandom_range(0, 63);
         end
         if ($urandom_range(0, 9) == 0)
            dest = source;
         case ($urandom_range(0, 9))
            0:       stops = 63;
            1:       stops = $urandom_range(6, 62);
            default: stops = $urandom_range(0, 5);
         endcase
         configure(nodes, source, dest, stops);
         repeat ($urandom_range(2, 6)) begin
            if (stops <= 2 && $urandom_range(0, 11) == 0)
               size = $urandom_range(240, 300);
            else if (stops > 5)
               size = $urandom_range(1, 10);
            else
               size = $urandom_range(1, 24);
            send_batch(size, ($urandom_range(0, 3) == 0) ? 30 : 5);
         end
      end

      wait_until_idle();
      $display("Run covered %0d in-range edge words in %0d batches over %0d register settings",
               board.counted_edges, board.batches, reg_settings);
      $display("%0d results checked, %0d routes found, %0d batches over capacity, %0d long holds",
               board.routes_checked, board.found_routes, board.dropped_batches, long_holds);
      $display("%0d mismatches", board.mismatches);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
